### sv/sap_pkg.sv
// Package for the stride address predictor.
// Holds the address width, the input and result word types and the
// confidence constants. No dependencies.
package sap_pkg;

  localparam int unsigned ADDR_BITS = 48;
  localparam int unsigned CONF_BITS = 2;

  localparam logic [CONF_BITS-1:0] CONF_MAX         = 2'd3;
  localparam logic [CONF_BITS-1:0] CONF_ZERO        = 2'd0;
  localparam logic [CONF_BITS-1:0] THRESHOLD_RESET  = 2'd2;

  typedef struct packed {
    logic [ADDR_BITS-1:0] instr_addr;
    logic [ADDR_BITS-1:0] data_addr;
  } in_word_t;

  typedef struct packed {
    logic                 pred_valid;
    logic [ADDR_BITS-1:0] target_addr;
  } out_word_t;

endpackage

### sv/stride_address_predictor.sv
// Stride address predictor top level: table memory, prediction and training
// pipeline, result register and the clearing pass after reset.
// Depends on sap_pkg.

// A direct-mapped table of TABLE_ENTRIES entries, indexed by the low bits of
// the load's instruction address, tracks the last data address, the stride
// and a two-bit confidence per load. Each input word yields exactly one
// result word: a prediction made from the entry as it stood, after which the
// entry is trained with the load's actual address. The table sits in one
// synchronous memory with a registered read port. A word is accepted and
// its entry is read into the read register at the edge that takes it; stage
// one then forms the prediction, and once the output register is free the
// updated entry is written back and the result is loaded into the output
// register. The read of one word overlaps the
// write-back of the one before it, and when both touch the same entry the
// written value is forwarded, so the block sustains one word per cycle; only
// a stalled output slows it. After reset a clearing pass marks each of the
// TABLE_ENTRIES entries invalid; during that time no input word is taken,
// though the threshold register may still be written. TABLE_ENTRIES must be
// a power of two.
module stride_address_predictor
  import sap_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CONF_BITS-1:0] cfg_wdata
);

  localparam int unsigned IDX_BITS    = $clog2(TABLE_ENTRIES);
  localparam int unsigned TAG_BITS    = ADDR_BITS - IDX_BITS;
  localparam int unsigned STRIDE_BITS = ADDR_BITS + 1;

  // One table entry as it is held in the memory. The stride is the exact
  // difference of two addresses, so it carries one bit more than an address.
  typedef struct packed {
    logic                   valid;
    logic [TAG_BITS-1:0]    tag;
    logic [ADDR_BITS-1:0]   prev_addr;
    logic [STRIDE_BITS-1:0] stride;
    logic [CONF_BITS-1:0]   conf;
  } entry_t;

  // Configuration register.
  logic [CONF_BITS-1:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // Clearing pass after reset: one entry is written invalid per cycle.
  logic                clearing;
  logic [IDX_BITS-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == IDX_BITS'(TABLE_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Handshake and pipeline control. Stage one holds the word whose entry
  // has just been read; it retires when the output register can take its
  // result.
  logic     s1_valid;
  in_word_t s1_word;
  logic     out_free;
  logic     s1_advance;
  logic     accept;

  assign out_free   = !out_valid || out_ready;
  assign s1_advance = s1_valid && out_free;
  assign in_ready   = !clearing && (!s1_valid || s1_advance);
  assign accept     = in_valid && in_ready;

  // Table memory and its registered read port.
  entry_t              table_mem [TABLE_ENTRIES];
  entry_t              rdata;
  logic                mem_we;
  logic [IDX_BITS-1:0] waddr;
  entry_t              wdata;
  logic [IDX_BITS-1:0] raddr;

  assign raddr = in_data.instr_addr[IDX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[waddr] <= wdata;
    end
    if (accept) begin
      rdata <= table_mem[raddr];
    end
  end

  // Forwarding: when the word being read hits the entry that stage one is
  // writing in the same cycle, the memory returns the old contents, so the
  // freshly written entry is kept aside and used instead.
  logic   fwd_hit;
  entry_t fwd_entry;
  entry_t train_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= s1_advance && (raddr == s1_word.instr_addr[IDX_BITS-1:0]);
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word   <= in_data;
      fwd_entry <= train_entry;
    end
  end

  // Stage one: prediction from the old entry, then training.
  entry_t                 cur;
  logic [TAG_BITS-1:0]    s1_tag;
  logic                   hit;
  logic                   pred_ok;
  logic [ADDR_BITS-1:0]   pred_sum;
  logic [STRIDE_BITS-1:0] step_delta;
  logic                   same_stride;

  always_comb begin
    cur         = fwd_hit ? fwd_entry : rdata;
    s1_tag      = s1_word.instr_addr[ADDR_BITS-1:IDX_BITS];
    hit         = cur.valid && (cur.tag == s1_tag);
    pred_ok     = hit && (cur.stride[ADDR_BITS-1:0] != '0) && (cur.conf >= threshold);
    pred_sum    = cur.prev_addr + cur.stride[ADDR_BITS-1:0];
    // The top bit of the widened difference is the borrow, set when the
    // actual address lies below the last one.
    step_delta  = {1'b0, s1_word.data_addr} - {1'b0, cur.prev_addr};
    same_stride = (step_delta == cur.stride);

    train_entry.valid     = 1'b1;
    train_entry.tag       = s1_tag;
    train_entry.prev_addr = s1_word.data_addr;
    if (!hit) begin
      train_entry.stride = '0;
      train_entry.conf   = CONF_ZERO;
    end else if (same_stride) begin
      train_entry.stride = cur.stride;
      train_entry.conf   = (cur.conf == CONF_MAX) ? CONF_MAX : cur.conf + 1'b1;
    end else begin
      train_entry.stride = step_delta;
      train_entry.conf   = (cur.conf == CONF_ZERO) ? CONF_ZERO : cur.conf - 1'b1;
    end
  end

  // Write port: the clearing pass owns it until it ends; no word is in
  // flight during that time.
  always_comb begin
    if (clearing) begin
      mem_we = 1'b1;
      waddr  = clr_idx;
      wdata  = '0;
    end else begin
      mem_we = s1_advance;
      waddr  = s1_word.instr_addr[IDX_BITS-1:0];
      wdata  = train_entry;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data.pred_valid  <= pred_ok;
      out_data.target_addr <= pred_ok ? pred_sum : '0;
    end
  end

  // No word may be taken while the table is still being cleared.
  a_no_accept_while_clearing : assert property (
    @(posedge clk) disable iff (rst) clearing |-> !in_ready
  ) else $error("input word accepted during the clearing pass");

  // A word in stage one can only exist once clearing has finished.
  a_stage_after_clear : assert property (
    @(posedge clk) disable iff (rst) s1_valid |-> !clearing
  ) else $error("stage one occupied during the clearing pass");

  // A stalled stage one blocks the input.
  a_stall_blocks_input : assert property (
    @(posedge clk) disable iff (rst) (s1_valid && !out_free) |-> !in_ready
  ) else $error("input accepted while stage one is stalled");

  // A new result only appears after stage one has retired a word.
  a_result_from_stage : assert property (
    @(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(s1_advance)
  ) else $error("result word appeared without a retiring stage");

  // A result without a prediction carries a zero address.
  a_zero_addr_when_no_pred : assert property (
    @(posedge clk) disable iff (rst)
      (out_valid && !out_data.pred_valid) |-> (out_data.target_addr == '0)
  ) else $error("nonzero predicted address without a prediction");

endmodule

### verif/tb_stride_address_predictor.sv
// Self-checking testbench for the stride address predictor.
// Drives load words through a table of directed rows and then random load streams,
// predicts each result word in its own table copy; depends on sap_pkg and the RTL.
module tb_stride_address_predictor;
  import sap_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int unsigned TAG_BITS      = ADDR_BITS - IDX_BITS;
  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 9;
  // Margin after the last result word lets the write-back settle before the
  // threshold moves.
  localparam int unsigned SETTLE_CYCLES = 6;
  // Longest correct quiet stretch is the clearing pass after reset, so the
  // watchdog limit sits well beyond the length of that pass.
  localparam int unsigned STALL_LIMIT   = 4 * TABLE_ENTRIES + 1000;
  localparam int unsigned POOL_SIZE     = 16;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned LOADS_PER_PHASE = 280;
  localparam int unsigned NUM_ROWS      = 29;
  localparam logic [ADDR_BITS-1:0] ADDR_TOP = '1;

  typedef enum logic {ROW_LOAD, ROW_THRESHOLD} row_kind_t;

  // One row of the directed table. Where typed is set the expected result
  // word is given by hand; otherwise the predictor supplies it.
  typedef struct {
    row_kind_t            kind;
    logic [CONF_BITS-1:0] thr;
    logic [ADDR_BITS-1:0] pc;
    logic [ADDR_BITS-1:0] act;
    logic                 typed;
    logic                 want_valid;
    logic [ADDR_BITS-1:0] want_addr;
  } dir_row_t;

  typedef struct {
    logic [CONF_BITS-1:0] thr;
    int unsigned          send_idle_pct;
    int unsigned          recv_stall_pct;
  } phase_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic                 cfg_we = 1'b0;
  logic [CONF_BITS-1:0] cfg_wdata = THRESHOLD_RESET;

  // Predictor state: a private copy of the table and of the threshold.
  logic                 tbl_valid  [TABLE_ENTRIES];
  logic [TAG_BITS-1:0]  tbl_tag    [TABLE_ENTRIES];
  logic [ADDR_BITS-1:0] tbl_last   [TABLE_ENTRIES];
  logic [ADDR_BITS:0]   tbl_stride [TABLE_ENTRIES];
  logic [CONF_BITS-1:0] tbl_conf   [TABLE_ENTRIES];
  logic [CONF_BITS-1:0] model_threshold = THRESHOLD_RESET;

  out_word_t   pending_predictions [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Random load streams: each slot is one load instruction walking memory
  // with its own stride.
  logic [ADDR_BITS-1:0] pool_pc     [POOL_SIZE];
  logic [ADDR_BITS-1:0] pool_act    [POOL_SIZE];
  logic [ADDR_BITS-1:0] pool_stride [POOL_SIZE];

  dir_row_t directed [NUM_ROWS] = '{
    // Fresh entry after reset misses, then a zero stride cannot predict.
    '{ROW_LOAD, 2'd0, 48'h0, 48'h0,  1'b1, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, 48'h0, 48'h10, 1'b1, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, 48'h0, 48'h20, 1'b1, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, 48'h0, 48'h30, 1'b1, 1'b0, 48'h0},
    // Confidence has reached the reset threshold of two.
    '{ROW_LOAD, 2'd0, 48'h0, 48'h40, 1'b1, 1'b1, 48'h40},
    '{ROW_LOAD, 2'd0, 48'h0, 48'h50, 1'b0, 1'b0, 48'h0},
    // Confidence saturates, then the stride breaks down to zero.
    '{ROW_LOAD, 2'd0, 48'h0, 48'h60, 1'b0, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, 48'h0, 48'h60, 1'b0, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, 48'h0, 48'h60, 1'b0, 1'b0, 48'h0},
    // Top index and top tag; stepping across the wrap gives a negative stride.
    '{ROW_LOAD, 2'd0, ADDR_TOP, ADDR_TOP, 1'b1, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, ADDR_TOP, 48'h0,    1'b0, 1'b0, 48'h0},
    // Same low stride bits with the opposite sign is a different stride.
    '{ROW_LOAD, 2'd0, ADDR_TOP, 48'h1,    1'b0, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, ADDR_TOP, 48'h2,    1'b0, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, ADDR_TOP, 48'h3,    1'b0, 1'b0, 48'h0},
    // Same index, other tag: the entry is taken over, and back again.
    '{ROW_LOAD, 2'd0, 48'h3FF,  48'h123,  1'b1, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, ADDR_TOP, 48'h6,    1'b1, 1'b0, 48'h0},
    // Descending stream: the prediction sum wraps at the address width.
    '{ROW_LOAD, 2'd0, 48'h5, 48'h100, 1'b0, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, 48'h5, 48'hF0,  1'b0, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, 48'h5, 48'hE0,  1'b0, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, 48'h5, 48'hD0,  1'b0, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, 48'h5, 48'hC0,  1'b0, 1'b0, 48'h0},
    // With the threshold at zero a nonzero stride predicts at confidence zero,
    // but a zero stride still never does.
    '{ROW_THRESHOLD, 2'd0, 48'h0, 48'h0, 1'b0, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, 48'h7, 48'h1000, 1'b0, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, 48'h7, 48'h1008, 1'b0, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, 48'h7, 48'h2000, 1'b0, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, 48'h7, 48'h2000, 1'b0, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, 48'h7, 48'h2000, 1'b0, 1'b0, 48'h0},
    // Highest threshold: only a saturated entry predicts.
    '{ROW_THRESHOLD, 2'd3, 48'h0, 48'h0, 1'b0, 1'b0, 48'h0},
    '{ROW_LOAD, 2'd0, 48'h5, 48'hB0,  1'b0, 1'b0, 48'h0}
  };

  // Random phases: each moves the threshold and changes how both sides idle.
  phase_t phases [NUM_PHASES] = '{
    '{2'd2, 0,  0},
    '{2'd0, 50, 0},
    '{2'd3, 0,  50},
    '{2'd1, 37, 37},
    '{2'd3, 0,  0},
    '{2'd2, 37, 37}
  };

  stride_address_predictor #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [ADDR_BITS-1:0] random_address();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[ADDR_BITS-1:0];
  endfunction

  // Mostly short strides of whole words, sometimes any distance, sometimes
  // none at all; either direction.
  function automatic logic [ADDR_BITS-1:0] pick_stride();
    logic [ADDR_BITS-1:0] s;
    case ($urandom_range(0, 9))
      0: begin
        s = '0;
      end
      1, 2: begin
        s = random_address();
      end
      default: begin
        s = ADDR_BITS'($urandom_range(1, 64) * 8);
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      s = -s;
    end
    return s;
  endfunction

  // Works out the result word for one load from the entry as it stands, then
  // trains the entry just as the block does.
  function automatic out_word_t predict_load(input in_word_t w);
    logic [IDX_BITS-1:0] idx;
    logic [TAG_BITS-1:0] tag;
    logic                hit;
    logic [ADDR_BITS:0]  delta;
    out_word_t           res;
    idx = w.instr_addr[IDX_BITS-1:0];
    tag = w.instr_addr[ADDR_BITS-1:IDX_BITS];
    hit = tbl_valid[idx] && (tbl_tag[idx] == tag);
    res.pred_valid  = hit && (tbl_stride[idx][ADDR_BITS-1:0] != '0) &&
                      (tbl_conf[idx] >= model_threshold);
    res.target_addr = res.pred_valid ? tbl_last[idx] + tbl_stride[idx][ADDR_BITS-1:0] : '0;
    if (!hit) begin
      tbl_valid[idx]  = 1'b1;
      tbl_tag[idx]    = tag;
      tbl_last[idx]   = w.data_addr;
      tbl_stride[idx] = '0;
      tbl_conf[idx]   = CONF_ZERO;
    end else begin
      // The stride is the exact difference, one bit wider than an address,
      // so a borrow keeps it apart from a positive stride of the same low bits.
      delta = {1'b0, w.data_addr} - {1'b0, tbl_last[idx]};
      if (delta == tbl_stride[idx]) begin
        if (tbl_conf[idx] != CONF_MAX) begin
          tbl_conf[idx] = tbl_conf[idx] + 1'b1;
        end
      end else begin
        if (tbl_conf[idx] != CONF_ZERO) begin
          tbl_conf[idx] = tbl_conf[idx] - 1'b1;
        end
        tbl_stride[idx] = delta;
      end
      tbl_last[idx] = w.data_addr;
    end
    return res;
  endfunction

  // Offers one load word, idling first at the sender's rate, and holds it
  // until the block takes it. Valid is left high on return so that a word
  // following straight on never sees valid drop.
  task automatic send_load(input in_word_t w, input logic typed, input out_word_t typed_word);
    out_word_t predicted;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do begin
      @(posedge clk);
    end while (!in_ready);
    // Taken at this edge; the predictor runs in acceptance order.
    predicted = predict_load(w);
    pending_predictions.push_back(typed ? typed_word : predicted);
  endtask

  // Stops offering, waits for every expected result word, then lets the
  // pipeline settle so that the block is idle.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_predictions.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CONF_BITS-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_threshold = thr;
  endtask

  // The receiver stalls at its own rate; at a rate of zero it is always ready.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Every result word taken is compared with the oldest prediction.
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_predictions.size() == 0) begin
        $error("unexpected result word: pred_valid %0b target_addr 'h%012h",
               out_data.pred_valid, out_data.target_addr);
        mismatches++;
      end else begin
        want = pending_predictions.pop_front();
        if (out_data.pred_valid !== want.pred_valid) begin
          $error("pred_valid: expected %0b, actual %0b", want.pred_valid, out_data.pred_valid);
          mismatches++;
        end
        if (out_data.target_addr !== want.target_addr) begin
          $error("target_addr: expected 'h%012h, actual 'h%012h",
                 want.target_addr, out_data.target_addr);
          mismatches++;
        end
      end
    end
  end

  // Ends a hung run: counts edges at which neither channel moves a word.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    in_word_t  w;
    out_word_t typed_word;
    int unsigned k;
    int unsigned r;
    foreach (tbl_valid[i]) begin
      tbl_valid[i]  = 1'b0;
      tbl_tag[i]    = '0;
      tbl_last[i]   = '0;
      tbl_stride[i] = '0;
      tbl_conf[i]   = CONF_ZERO;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed rows start at the reset threshold and run with no idling on either side.
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_THRESHOLD) begin
        drain_block();
        write_threshold(directed[i].thr);
      end else begin
        w.instr_addr           = directed[i].pc;
        w.data_addr            = directed[i].act;
        typed_word.pred_valid  = directed[i].want_valid;
        typed_word.target_addr = directed[i].want_addr;
        send_load(w, directed[i].typed, typed_word);
      end
    end

    typed_word = '0;
    foreach (phases[p]) begin
      drain_block();
      write_threshold(phases[p].thr);
      send_idle_pct  = phases[p].send_idle_pct;
      recv_stall_pct = phases[p].recv_stall_pct;
      // Fresh streams each phase. Slots four and five share an index with
      // slots zero and one under another tag, so those pairs evict each other.
      for (int s = 0; s < POOL_SIZE; s++) begin
        pool_pc[s] = random_address();
        if (s == 4 || s == 5) begin
          pool_pc[s][IDX_BITS-1:0] = pool_pc[s - 4][IDX_BITS-1:0];
        end
        pool_act[s]    = random_address();
        pool_stride[s] = pick_stride();
      end
      for (int n = 0; n < LOADS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // Noise: any instruction at any address.
          w.instr_addr = random_address();
          w.data_addr  = random_address();
        end else begin
          k = $urandom_range(0, POOL_SIZE - 1);
          if (r < 13) begin
            pool_stride[k] = pick_stride();
          end
          if ($urandom_range(0, 99) < 4) begin
            pool_act[k] = random_address();
          end else begin
            pool_act[k] = pool_act[k] + pool_stride[k];
          end
          w.instr_addr = pool_pc[k];
          w.data_addr  = pool_act[k];
        end
        send_load(w, 1'b0, typed_word);
      end
    end

    drain_block();
    if (mismatches == 0 && pending_predictions.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
